### rtl/json_string_unescape_utf8_macros.svh
// Assertion macros shared by the JSON string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/jsu_pkg.sv
// Package with types, constants and helpers of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

   // Largest number of output bytes one request can cause
   localparam int BURST_MAX = 6;
   localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);
   localparam int BURST_IDX_W = $clog2(BURST_MAX);

   // Queue between front and back, in bursts
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Number of held hex digits kept for replay
   localparam int HELD_DEPTH = 3;

   // Characters
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;

   // UTF-8 limits and lead/continuation marks
   localparam logic [15:0] UTF8_MAX1 = 16'h007F;
   localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
   localparam logic [2:0]  UTF8_LEAD2 = 3'b110;   // 0xC0
   localparam logic [3:0]  UTF8_LEAD3 = 4'b1110;  // 0xE0
   localparam logic [1:0]  UTF8_CONT  = 2'b10;    // 0x80, payload mask 0x3F

   // Parse mode
   typedef enum logic [2:0] {
      MODE_PLAIN = 3'b001,
      MODE_ESC   = 3'b010,
      MODE_HEX   = 3'b100
   } mode_type;

   // Output bytes caused by one request
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [BURST_CNT_W-1:0]    count;
      logic                      last;
   } burst_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

   // Hex digit decode: {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, b[3:0]};
      end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/jsu_queue.sv
// Short burst queue between the parsing front and the byte-serializing back.
`default_nettype none
module jsu_queue import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  burst_type  push_data,
   input  logic       pop,
   output burst_type  head,
   output q_stat_type q_stat
);

   burst_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store burst
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign q_stat.valid = (count_ff != '0);
   assign q_stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule
`default_nettype wire

### rtl/jsu_front.sv
// Front end: accepts raw bytes, tracks escape state and builds output bursts.
`default_nettype none
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  q_stat_type q_stat,
   output logic       push,
   output burst_type  push_data
);

   mode_type                      mode_ff, mode_in;
   logic [1:0]                    hex_count_ff, hex_count_in;
   logic [11:0]                   hex_accum_ff, hex_accum_in;
   logic [HELD_DEPTH-1:0][7:0]    held_ff, held_in;

   logic                          accept;
   logic [4:0]                    hex;
   logic [15:0]                   cp;
   logic [1:0]                    replay_cnt;
   logic                          do_replay;
   logic                          do_plain;
   logic [BURST_MAX-1:0][7:0]     obytes;
   logic [BURST_CNT_W-1:0]        n;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign hex       = hex_decode(req_in_byte);
   assign cp        = {hex_accum_ff, hex[3:0]};

   // Decide next state and the output bytes of this request
   always_comb begin
      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      hex_accum_in = hex_accum_ff;
      held_in      = held_ff;
      replay_cnt   = hex_count_ff;
      do_replay    = 1'b0;
      do_plain     = 1'b0;
      obytes       = '0;
      n            = '0;

      case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            case (req_in_byte)
               CH_LOW_B: begin obytes[n] = CH_BS;  n = n + 1'b1; end
               CH_LOW_F: begin obytes[n] = CH_FF;  n = n + 1'b1; end
               CH_LOW_N: begin obytes[n] = CH_LF;  n = n + 1'b1; end
               CH_LOW_R: begin obytes[n] = CH_CR;  n = n + 1'b1; end
               CH_LOW_T: begin obytes[n] = CH_TAB; n = n + 1'b1; end
               CH_LOW_U: begin
                  if (req_in_last) begin
                     obytes[n] = CH_BSLASH; n = n + 1'b1;
                     obytes[n] = CH_LOW_U;  n = n + 1'b1;
                  end else begin
                     mode_in      = MODE_HEX;
                     hex_count_in = '0;
                     hex_accum_in = '0;
                  end
               end
               default: begin obytes[n] = req_in_byte; n = n + 1'b1; end
            endcase
         end
         MODE_HEX: begin
            if (!hex[4]) begin
               // Cut-short escape: replay, then treat byte as plain text
               do_replay = 1'b1;
               do_plain  = 1'b1;
            end else if (hex_count_ff == 2'd3) begin
               // Fourth digit: encode code point as UTF-8
               if (cp <= UTF8_MAX1) begin
                  obytes[n] = cp[7:0]; n = n + 1'b1;
               end else if (cp <= UTF8_MAX2) begin
                  obytes[n] = {UTF8_LEAD2, cp[10:6]}; n = n + 1'b1;
                  obytes[n] = {UTF8_CONT, cp[5:0]};   n = n + 1'b1;
               end else begin
                  obytes[n] = {UTF8_LEAD3, cp[15:12]}; n = n + 1'b1;
                  obytes[n] = {UTF8_CONT, cp[11:6]};   n = n + 1'b1;
                  obytes[n] = {UTF8_CONT, cp[5:0]};    n = n + 1'b1;
               end
               mode_in      = MODE_PLAIN;
               hex_count_in = '0;
               hex_accum_in = '0;
            end else begin
               // Hold digit for a possible replay
               held_in[hex_count_ff] = req_in_byte;
               hex_accum_in          = {hex_accum_ff[7:0], hex[3:0]};
               hex_count_in          = hex_count_ff + 1'b1;
               replay_cnt            = hex_count_ff + 1'b1;
               do_replay             = req_in_last;
            end
         end
         default: begin
            do_plain = 1'b1;
         end
      endcase

      // Emit backslash, u and the held digits
      if (do_replay) begin
         obytes[n] = CH_BSLASH; n = n + 1'b1;
         obytes[n] = CH_LOW_U;  n = n + 1'b1;
         for (int i = 0; i < HELD_DEPTH; i++) begin
            if (2'(i) < replay_cnt) begin
               obytes[n] = held_in[i];
               n = n + 1'b1;
            end
         end
         mode_in      = MODE_PLAIN;
         hex_count_in = '0;
         hex_accum_in = '0;
      end

      // Plain text: a backslash opens an escape unless it ends the string
      if (do_plain) begin
         mode_in = MODE_PLAIN;
         if (req_in_byte == CH_BSLASH && !req_in_last) begin
            mode_in = MODE_ESC;
         end else begin
            obytes[n] = req_in_byte;
            n = n + 1'b1;
         end
      end

      // End of string drops any partial escape
      if (req_in_last) begin
         mode_in      = MODE_PLAIN;
         hex_count_in = '0;
         hex_accum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         hex_count_ff <= '0;
         hex_accum_ff <= '0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         hex_accum_ff <= hex_accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   assign push            = accept && (n != '0);
   assign push_data.bytes = obytes;
   assign push_data.count = n;
   assign push_data.last  = req_in_last;

endmodule
`default_nettype wire

### rtl/jsu_back.sv
// Back end: walks the head burst one byte a cycle, unless stalled, into the response register.
`default_nettype none
module jsu_back import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  burst_type  head,
   input  q_stat_type q_stat,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic [BURST_IDX_W-1:0] idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   load;
   logic                   final_byte;

   assign load       = q_stat.valid && (!rsp_valid_ff || !rsp_stall);
   assign final_byte = (BURST_CNT_W'(idx_ff) == head.count - 1'b1);
   assign pop        = load && final_byte;

   // Advance through the burst; hold the response while stalled
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = head.bytes[idx_ff];
         rsp_last_in  = head.last && final_byte;
         idx_in       = final_byte ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule
`default_nettype wire

### rtl/json_string_unescape_utf8.sv
// Bytes pass the burst queue, then the response register. Throughput: one request
// per cycle while each yields at most one byte and the output is not stalled; the
// output register sends one byte per cycle, so escape bursts (up to six bytes)
// drain through a four-burst queue and the front stalls only when it is full.
// Reset (synchronous, active high) returns to plain text and empties the queue.
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"
module json_string_unescape_utf8 import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic       push;
   logic       pop;
   burst_type  push_data;
   burst_type  head;
   q_stat_type q_stat;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_stat      (q_stat),
      .push        (push),
      .push_data   (push_data)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_stat       (q_stat),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   // An empty queue never stalls the front
   `JSU_ASSERT_NOW(a_empty_no_stall, clock, reset, !q_stat.valid, !req_stall, "stall with empty queue")
   // A queued burst always carries between one and six bytes
   `JSU_ASSERT_NOW(a_head_count, clock, reset, q_stat.valid, (head.count != '0) && (head.count <= BURST_CNT_W'(BURST_MAX)), "bad burst count")
   // A final byte always leaves a burst in the queue
   `JSU_ASSERT_NEXT(a_last_pushes, clock, reset, req_valid && !req_stall && req_in_last, q_stat.valid, "final byte gave no output")

endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for the JSON string unescaper: directed and random strings checked byte by byte.
`timescale 1ns / 100ps
module tb import jsu_pkg::*;;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 310;
   localparam int CALM_FROM    = 270;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_MAX   = 10;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_LO_A  = 8'h61;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   // Predicted unescaper state
   mode_type   scan_mode = MODE_PLAIN;
   int         digits_seen = 0;
   logic [11:0] code_sofar = '0;
   logic [7:0] digit_bytes [3] = '{default: 8'h00};

   out_beat_type pending_out [$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         sent_count = 0;
   bit         idle_on = 1'b1;
   int         stall_left = 0;

   json_string_unescape_utf8 dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = 4'h0;
      if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
         v = c[3:0];
         return 1'b1;
      end
      if (c >= CH_LO_A && c <= CH_LO_A + 8'd5) begin
         v = 4'(c - CH_LO_A + 8'd10);
         return 1'b1;
      end
      if (c >= CH_UP_A && c <= CH_UP_A + 8'd5) begin
         v = 4'(c - CH_UP_A + 8'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void push_out(input logic [7:0] b);
      out_beat_type beat;
      beat.data = b;
      beat.last = 1'b0;
      pending_out.insert(pending_out.size(), beat);
   endfunction

   function automatic void clear_digits();
      scan_mode = MODE_PLAIN;
      digits_seen = 0;
      code_sofar = '0;
   endfunction

   // Replay a cut-short \u: backslash, 'u' and the digits held so far
   function automatic void replay_digits();
      push_out(CH_BSLASH);
      push_out(CH_LOW_U);
      for (int i = 0; i < digits_seen; i++) begin
         push_out(digit_bytes[i]);
      end
      clear_digits();
   endfunction

   function automatic void take_plain(input logic [7:0] b, input logic last);
      if (b == CH_BSLASH && !last) begin
         scan_mode = MODE_ESC;
      end else begin
         push_out(b);
      end
   endfunction

   // Queue the output bytes that one accepted request causes
   function automatic void unescape_predict(input logic [7:0] b, input logic last);
      logic [3:0]  nib;
      logic [15:0] cp;
      int          first;
      first = pending_out.size();
      case (scan_mode)
         MODE_ESC: begin
            scan_mode = MODE_PLAIN;
            case (b)
               CH_LOW_B: push_out(CH_BS);
               CH_LOW_F: push_out(CH_FF);
               CH_LOW_N: push_out(CH_LF);
               CH_LOW_R: push_out(CH_CR);
               CH_LOW_T: push_out(CH_TAB);
               CH_LOW_U: begin
                  if (last) begin
                     push_out(CH_BSLASH);
                     push_out(CH_LOW_U);
                  end else begin
                     scan_mode = MODE_HEX;
                     digits_seen = 0;
                     code_sofar = '0;
                  end
               end
               default: push_out(b);
            endcase
         end
         MODE_HEX: begin
            if (!hex_nibble(b, nib)) begin
               replay_digits();
               take_plain(b, last);
            end else if (digits_seen == 3) begin
               cp = {code_sofar, nib};
               if (cp <= UTF8_MAX1) begin
                  push_out(cp[7:0]);
               end else if (cp <= UTF8_MAX2) begin
                  push_out({UTF8_LEAD2, cp[10:6]});
                  push_out({UTF8_CONT, cp[5:0]});
               end else begin
                  push_out({UTF8_LEAD3, cp[15:12]});
                  push_out({UTF8_CONT, cp[11:6]});
                  push_out({UTF8_CONT, cp[5:0]});
               end
               clear_digits();
            end else begin
               digit_bytes[digits_seen] = b;
               code_sofar = {code_sofar[7:0], nib};
               digits_seen++;
               if (last) begin
                  replay_digits();
               end
            end
         end
         default: take_plain(b, last);
      endcase
      // Close the string: back to plain text, flag its final output byte
      if (last) begin
         clear_digits();
         if (pending_out.size() > first) begin
            pending_out[pending_out.size() - 1].last = 1'b1;
         end
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endfunction

   // Compare each accepted output byte with the oldest prediction
   always @(posedge clock) begin : check_output
      out_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_out.size() == 0) begin
            note_error($sformatf("unexpected byte %02h last %0b", rsp_out_byte, rsp_out_last));
         end else begin
            want = pending_out.pop_front();
            if (rsp_out_byte !== want.data || rsp_out_last !== want.last) begin
               note_error($sformatf("expected byte %02h last %0b, got %02h last %0b",
                                    want.data, want.last, rsp_out_byte, rsp_out_last));
            end
         end
      end
   end

   // Stall the output side in random bursts
   always @(posedge clock) begin
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 12);
      end
      if (!idle_on) begin
         stall_left = 0;
      end
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) begin
         stall_left--;
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Send one request, with an optional gap ahead of it; predict on acceptance
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      unescape_predict(b, last);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return CH_ZERO + 8'(n);
      end
      return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(n) - 8'd10;
   endfunction

   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // trailing lone backslash
      send_byte(CH_BSLASH, 1'b1);
   endtask

   task automatic test_simple_escapes();
      send_text("\\b\\f\\n\\r\\t");
   endtask

   task automatic test_unicode_escape();
      send_text("\\u07FF");
   endtask

   task automatic test_cut_short();
      // non-hex byte that opens a new escape
      send_text("\\u12\\\"");
      // string ends right after the u
      send_text("\\u");
   endtask

   task automatic test_random_strings();
      logic [7:0]  txt [$];
      logic [3:0]  nib;
      logic [7:0]  b;
      logic [15:0] cp;
      int          pieces;
      int          ndig;
      while (sent_count < RANDOM_ITEMS) begin
         txt.delete();
         pieces = $urandom_range(1, 8);
         for (int p = 0; p < pieces; p++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
               3: txt.insert(txt.size(), 8'($urandom_range(8'h20, 8'h7E)));
               4: begin
                  txt.insert(txt.size(), CH_BSLASH);
                  case ($urandom_range(0, 7))
                     0: txt.insert(txt.size(), CH_LOW_B);
                     1: txt.insert(txt.size(), CH_LOW_F);
                     2: txt.insert(txt.size(), CH_LOW_N);
                     3: txt.insert(txt.size(), CH_LOW_R);
                     4: txt.insert(txt.size(), CH_LOW_T);
                     5: txt.insert(txt.size(), CH_QUOTE);
                     6: txt.insert(txt.size(), CH_SLASH);
                     default: txt.insert(txt.size(), CH_BSLASH);
                  endcase
               end
               5: begin
                  txt.insert(txt.size(), CH_BSLASH);
                  txt.insert(txt.size(), 8'($urandom_range(0, 255)));
               end
               6, 7: begin
                  txt.insert(txt.size(), CH_BSLASH);
                  txt.insert(txt.size(), CH_LOW_U);
                  case ($urandom_range(0, 3))
                     0: cp = 16'($urandom_range(0, 16'h007F));
                     1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                     2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                     default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                  endcase
                  for (int k = 3; k >= 0; k--) begin
                     txt.insert(txt.size(), hex_char(cp[k*4 +: 4]));
                  end
               end
               8: begin
                  txt.insert(txt.size(), CH_BSLASH);
                  txt.insert(txt.size(), CH_LOW_U);
                  ndig = $urandom_range(0, 3);
                  for (int k = 0; k < ndig; k++) begin
                     txt.insert(txt.size(), hex_char(4'($urandom_range(0, 15))));
                  end
                  // break the escape with a non-hex byte, or leave it open
                  if ($urandom_range(0, 3) != 0) begin
                     do b = 8'($urandom_range(0, 255)); while (hex_nibble(b, nib));
                     txt.insert(txt.size(), b);
                  end
               end
               default: txt.insert(txt.size(), CH_BSLASH);
            endcase
         end
         // calm final stretch, and some calm strings along the way
         idle_on = (sent_count < CALM_FROM) && ($urandom_range(0, 3) != 0);
         foreach (txt[i]) begin
            send_byte(txt[i], i == txt.size() - 1);
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_simple_escapes();
      test_unicode_escape();
      test_cut_short();
      test_random_strings();
      req_valid <= 1'b0;
      // drain outstanding output bytes
      while (pending_out.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
